// ===== rtl/core/aabbfc_pkg.sv =====
package aabbfc_pkg;

    // Field widths
    localparam int COORD_WIDTH = 32;
    localparam int HALF_WIDTH  = COORD_WIDTH - 1;
    localparam int MAT_W       = 32;

    // Configuration port
    localparam int NUM_REGS   = 8;
    localparam int REG_SEL_W  = $clog2(NUM_REGS);
    localparam int CFG_IDX_W  = REG_SEL_W + 1;
    localparam int CFG_DATA_W = 2 * MAT_W;

    // Geometry
    localparam int NUM_ROWS    = 4;
    localparam int NUM_AXES    = 3;
    localparam int NUM_CORNERS = 8;
    localparam int NUM_PLANES  = 6;

    // Constant 1.0 in Q16.16 is a left shift by the fraction width
    localparam int ONE_SHIFT = 16;

    // Datapath widths: product, row base sum, corner coordinate, plane test
    localparam int PROD_W = MAT_W + COORD_WIDTH;
    localparam int BASE_W = PROD_W + 2;
    localparam int CRD_W  = BASE_W + 2;
    localparam int TEST_W = CRD_W + 1;

    // Matrix rows give clip coordinates X, Y, Z, W
    localparam int ROW_X = 0;
    localparam int ROW_Y = 1;
    localparam int ROW_Z = 2;
    localparam int ROW_W = 3;

    // Outside mask bit positions
    localparam int PL_FAR   = 0;
    localparam int PL_NEAR  = 1;
    localparam int PL_LEFT  = 2;
    localparam int PL_RIGHT = 3;
    localparam int PL_UP    = 4;
    localparam int PL_DOWN  = 5;

    typedef logic [NUM_ROWS-1:0][NUM_ROWS-1:0][MAT_W-1:0]   t_mat;
    typedef logic [NUM_AXES-1:0][COORD_WIDTH-1:0]           t_ctr;
    typedef logic [NUM_AXES-1:0][HALF_WIDTH-1:0]            t_half;
    typedef logic [NUM_PLANES-1:0]                          t_mask;
    typedef logic [NUM_CORNERS-1:0][NUM_ROWS-1:0][CRD_W-1:0] t_corners;

endpackage

// ===== rtl/core/aabbfc_cfg_regs.sv =====
module aabbfc_cfg_regs
    import aabbfc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_cfg_ready,
    output t_mat                  o_mat
);

    logic [CFG_DATA_W-1:0] r_regs [NUM_REGS];
    logic                  cfg_hit;

    assign o_cfg_ready = 1'b1;
    assign cfg_hit     = i_cfg_valid && (i_cfg_index < CFG_IDX_W'(NUM_REGS));

    // Write matrix registers; drop writes beyond the register list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_regs[i] <= '0;
            end
        end else if (cfg_hit) begin
            r_regs[i_cfg_index[REG_SEL_W-1:0]] <= i_cfg_data;
        end
    end

    // Each register holds two columns of one row, even column in the low word
    for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
        for (genvar c = 0; c < NUM_ROWS; c++) begin : g_col
            assign o_mat[r][c] = r_regs[r * 2 + c / 2][(c % 2) * MAT_W +: MAT_W];
        end
    end

    a_cfg_write : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_hit |=> r_regs[$past(i_cfg_index[REG_SEL_W-1:0])] == $past(i_cfg_data))
        else $error("matrix register did not take the written value");

endmodule

// ===== rtl/core/aabbfc_transform.sv =====
module aabbfc_transform
    import aabbfc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mat     i_mat,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_ctr     i_ctr,
    input  t_half    i_half,
    output logic     o_valid,
    input  logic     i_ready,
    output t_corners o_crd
);

    logic                     r_v1, r_v2, r_v3;
    logic                     ready1, ready2, ready3;

    logic signed [PROD_W-1:0] n_pc [NUM_ROWS][NUM_AXES];
    logic signed [PROD_W-1:0] n_ph [NUM_ROWS][NUM_AXES];
    logic signed [PROD_W-1:0] r_pc [NUM_ROWS][NUM_AXES];
    logic signed [PROD_W-1:0] r_ph [NUM_ROWS][NUM_AXES];
    logic signed [MAT_W-1:0]  r_pk [NUM_ROWS];

    logic signed [BASE_W-1:0] n_base [NUM_ROWS];
    logic signed [BASE_W-1:0] r_base [NUM_ROWS];
    logic signed [PROD_W-1:0] r_h2 [NUM_ROWS][NUM_AXES];

    t_corners                 n_crd;
    t_corners                 r_crd;

    // Per-stage flow control: a stage takes new data when empty or draining
    assign ready3  = !r_v3 || i_ready;
    assign ready2  = !r_v2 || ready3;
    assign ready1  = !r_v1 || ready2;
    assign o_ready = ready1;
    assign o_valid = r_v3;
    assign o_crd   = r_crd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (ready1) r_v1 <= i_valid;
            if (ready2) r_v2 <= r_v1;
            if (ready3) r_v3 <= r_v2;
        end
    end

    // Stage 1: matrix times center and matrix times half extent, per row and axis
    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                n_pc[r][a] = $signed(i_mat[r][a]) * $signed(i_ctr[a]);
                n_ph[r][a] = $signed(i_mat[r][a]) * $signed({1'b0, i_half[a]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready1) begin
            r_pc <= n_pc;
            r_ph <= n_ph;
            for (int r = 0; r < NUM_ROWS; r++) begin
                r_pk[r] <= $signed(i_mat[r][NUM_ROWS-1]);
            end
        end
    end

    // Stage 2: clip coordinate of the box center per row, translation times 1.0
    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            n_base[r] = BASE_W'(r_pc[r][0]) + BASE_W'(r_pc[r][1]) + BASE_W'(r_pc[r][2])
                      + (BASE_W'(r_pk[r]) <<< ONE_SHIFT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready2) begin
            r_base <= n_base;
            r_h2   <= r_ph;
        end
    end

    // Stage 3: add or subtract the half-extent terms for each of the eight corners
    always_comb begin
        logic signed [CRD_W-1:0] acc;
        acc = '0;
        for (int k = 0; k < NUM_CORNERS; k++) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                acc = CRD_W'(r_base[r]);
                for (int a = 0; a < NUM_AXES; a++) begin
                    if (((k >> a) & 1) != 0) begin
                        acc = acc + CRD_W'(r_h2[r][a]);
                    end else begin
                        acc = acc - CRD_W'(r_h2[r][a]);
                    end
                end
                n_crd[k][r] = acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready3) begin
            r_crd <= n_crd;
        end
    end

endmodule

// ===== rtl/core/aabbfc_plane_test.sv =====
module aabbfc_plane_test
    import aabbfc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_corners i_crd,
    output logic     o_valid,
    input  logic     i_stall,
    output logic     o_visible,
    output t_mask    o_outside_mask
);

    logic  r_v4, r_v5;
    logic  ready4, ready5;
    t_mask n_flags [NUM_CORNERS];
    t_mask r_flags [NUM_CORNERS];
    t_mask n_mask;
    t_mask r_mask;
    logic  r_visible;

    assign ready5         = !r_v5 || !i_stall;
    assign ready4         = !r_v4 || ready5;
    assign o_ready        = ready4;
    assign o_valid        = r_v5;
    assign o_visible      = r_visible;
    assign o_outside_mask = r_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (ready4) r_v4 <= i_valid;
            if (ready5) r_v5 <= r_v4;
        end
    end

    // Stage 4: strict tests of each corner against the six clip planes
    always_comb begin
        logic signed [TEST_W-1:0] x, y, z, w;
        x = '0;
        y = '0;
        z = '0;
        w = '0;
        for (int k = 0; k < NUM_CORNERS; k++) begin
            x = TEST_W'($signed(i_crd[k][ROW_X]));
            y = TEST_W'($signed(i_crd[k][ROW_Y]));
            z = TEST_W'($signed(i_crd[k][ROW_Z]));
            w = TEST_W'($signed(i_crd[k][ROW_W]));
            n_flags[k][PL_FAR]   = (z - w) > 0;
            n_flags[k][PL_NEAR]  = z < 0;
            n_flags[k][PL_LEFT]  = (x + w) < 0;
            n_flags[k][PL_RIGHT] = (x - w) > 0;
            n_flags[k][PL_UP]    = (y - w) > 0;
            n_flags[k][PL_DOWN]  = (y + w) < 0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready4) begin
            r_flags <= n_flags;
        end
    end

    // Stage 5: keep only planes that every corner lies past
    always_comb begin
        n_mask = '1;
        for (int k = 0; k < NUM_CORNERS; k++) begin
            n_mask = n_mask & r_flags[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready5) begin
            r_mask    <= n_mask;
            r_visible <= (n_mask == '0);
        end
    end

endmodule

// ===== rtl/core/aabb_frustum_cull_unit.sv =====
// Clip-space box culling, one box per transaction, five register stages.
// Each box passes through the stage registers in order, stage 1 to stage 5,
// and the last stage holds its result while the output is stalled.
// Throughput: one box per cycle unless the output stalls; stages share no logic.
// Reset clears all stage valid bits and sets the clip matrix to zero, which
// reports every box as visible until the matrix is written.
module aabb_frustum_cull_unit
    import aabbfc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,

    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [COORD_WIDTH-1:0] i_center_x,
    input  logic [COORD_WIDTH-1:0] i_center_y,
    input  logic [COORD_WIDTH-1:0] i_center_z,
    input  logic [HALF_WIDTH-1:0]  i_half_x,
    input  logic [HALF_WIDTH-1:0]  i_half_y,
    input  logic [HALF_WIDTH-1:0]  i_half_z,

    output logic                   o_valid,
    input  logic                   i_stall,
    output logic                   o_visible,
    output logic [NUM_PLANES-1:0]  o_outside_mask
);

    t_mat     mat;
    t_ctr     ctr;
    t_half    half;
    t_corners crd;
    logic     xf_ready;
    logic     xf_valid;
    logic     pt_ready;

    assign ctr  = {i_center_z, i_center_y, i_center_x};
    assign half = {i_half_z, i_half_y, i_half_x};

    assign o_stall = !xf_ready;

    aabbfc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_mat       (mat)
    );

    aabbfc_transform u_xf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mat   (mat),
        .i_valid (i_valid),
        .o_ready (xf_ready),
        .i_ctr   (ctr),
        .i_half  (half),
        .o_valid (xf_valid),
        .i_ready (pt_ready),
        .o_crd   (crd)
    );

    aabbfc_plane_test u_pt (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (xf_valid),
        .o_ready        (pt_ready),
        .i_crd          (crd),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_visible      (o_visible),
        .o_outside_mask (o_outside_mask)
    );

    // Input back-pressure only arises from a full pipe behind a stalled output
    a_stall_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while the pipeline has room");

    a_vis_mask : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_visible == (o_outside_mask == '0)))
        else $error("visible flag disagrees with outside mask");

    a_pipe_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("pipeline not empty after reset");

endmodule
